FILE: hw/rtl/multi_region_refinement_tagger_core_assert.svh
// ------------------------------------------------------------------------------------------
// Refinement tagger assertion macros
// Concurrent assertion shorthands used by the checker of the tagger core.
// ------------------------------------------------------------------------------------------
`ifndef MULTI_REGION_REFINEMENT_TAGGER_CORE_ASSERT_SVH
`define MULTI_REGION_REFINEMENT_TAGGER_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define MRRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define MRRT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: hw/rtl/mrrt_pkg.sv
// ------------------------------------------------------------------------------------------
// Refinement tagger package
// Register map, pipeline depths and shared types of the tagger core.
// ------------------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrrt_pkg;

    localparam int CFG_DATA_W  = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_REGIONS = 3;
    localparam int CTRL_W      = 6;
    localparam int CTRL_SHAPE_LSB = 3;
    localparam int AXES        = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CONTROL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADII0  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RADII1  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADII2  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING = 3'd7;

    localparam int FRONT_LAT = 2;
    localparam int SPH_LAT   = 6;
    localparam int PIPE_LAT  = 1 + FRONT_LAT + SPH_LAT + 1;

    typedef struct packed {
        logic active;
        logic cube;
    } t_region_ctrl;

endpackage

`default_nettype wire

FILE: hw/rtl/mrrt_cfg_regs.sv
// ------------------------------------------------------------------------------------------
// Refinement tagger configuration registers
// Write-only register file; splits the packed registers into per-axis fields.
// ------------------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrrt_cfg_regs
    import mrrt_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                             i_clk,
    input  wire logic                                             i_rst_n,
    input  wire logic                                             i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                             i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]                            i_cfg_wdata,
    output t_region_ctrl [CFG_REGIONS-1:0]                        o_ctrl,
    output logic [CFG_REGIONS-1:0][AXES-1:0][COORD_BITS-1:0]      o_center,
    output logic [CFG_REGIONS-1:0][AXES-1:0][COORD_BITS-1:0]      o_radii,
    output logic [AXES-1:0][COORD_BITS-1:0]                       o_spacing
);

    localparam int PACK_W = AXES * COORD_BITS;

    logic [CTRL_W-1:0]                        r_control;
    logic [CFG_REGIONS-1:0][CFG_DATA_W-1:0]   r_center;
    logic [CFG_REGIONS-1:0][CFG_DATA_W-1:0]   r_radii;
    logic [CFG_DATA_W-1:0]                    r_spacing;

    function automatic logic [PACK_W-1:0] widen(input logic [CFG_DATA_W-1:0] v);
        logic [PACK_W+CFG_DATA_W-1:0] ext;
        ext = {{PACK_W{1'b0}}, v};
        return ext[PACK_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control <= '0;
            r_center  <= '0;
            r_radii   <= '0;
            r_spacing <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_CONTROL: r_control   <= i_cfg_wdata[CTRL_W-1:0];
                REG_CENTER0: r_center[0] <= i_cfg_wdata;
                REG_CENTER1: r_center[1] <= i_cfg_wdata;
                REG_CENTER2: r_center[2] <= i_cfg_wdata;
                REG_RADII0:  r_radii[0]  <= i_cfg_wdata;
                REG_RADII1:  r_radii[1]  <= i_cfg_wdata;
                REG_RADII2:  r_radii[2]  <= i_cfg_wdata;
                REG_SPACING: r_spacing   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    genvar g_r;
    generate
        for (g_r = 0; g_r < CFG_REGIONS; g_r++) begin : g_region
            assign o_ctrl[g_r].active = r_control[g_r];
            assign o_ctrl[g_r].cube   = r_control[CTRL_SHAPE_LSB + g_r];
            assign o_center[g_r]      = widen(r_center[g_r]);
            assign o_radii[g_r]       = widen(r_radii[g_r]);
        end
    endgenerate

    assign o_spacing = widen(r_spacing);

endmodule

`default_nettype wire

FILE: hw/rtl/mrrt_region_front.sv
// ------------------------------------------------------------------------------------------
// Refinement tagger region front end
// Two stages: offsets and effective radii, then absolute offsets and the box test.
// ------------------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrrt_region_front
    import mrrt_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic [AXES-1:0][COORD_BITS-1:0]        i_point,
    input  wire logic [AXES-1:0][COORD_BITS-1:0]        i_center,
    input  wire logic [AXES-1:0][COORD_BITS-1:0]        i_radii,
    input  wire logic [AXES-1:0][COORD_BITS-1:0]        i_spacing,
    output logic                                        o_ok,
    output logic [AXES-1:0][COORD_BITS-1:0]             o_off,
    output logic [AXES-1:0][COORD_BITS-1:0]             o_rad
);

    localparam int W = COORD_BITS;

    logic [AXES-1:0][W:0]   r_diff;
    logic [AXES-1:0][W:0]   r_reff;
    logic [AXES-1:0][W:0]   n_diff;
    logic [AXES-1:0][W:0]   n_reff;

    logic                   r_ok;
    logic [AXES-1:0][W-1:0] r_off;
    logic [AXES-1:0][W-1:0] r_rad;
    logic                   n_ok;
    logic [AXES-1:0][W-1:0] n_off;
    logic [AXES-1:0][W-1:0] n_rad;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_diff[a] = {i_point[a][W-1], i_point[a]} - {i_center[a][W-1], i_center[a]};
            n_reff[a] = {1'b0, i_radii[a]} - {1'b0, i_spacing[a]};
        end
    end

    always_comb begin
        logic [W:0] mag;
        n_ok = 1'b1;
        mag  = '0;
        for (int a = 0; a < AXES; a++) begin
            mag = r_diff[a][W] ? (~r_diff[a] + 1'b1) : r_diff[a];
            if (r_reff[a][W] || (r_reff[a] == '0) || (mag > r_reff[a])) begin
                n_ok = 1'b0;
            end
            n_off[a] = mag[W-1:0];
            n_rad[a] = r_reff[a][W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff <= n_diff;
        r_reff <= n_reff;
        r_ok   <= n_ok;
        r_off  <= n_off;
        r_rad  <= n_rad;
    end

    assign o_ok  = r_ok;
    assign o_off = r_off;
    assign o_rad = r_rad;

endmodule

`default_nettype wire

FILE: hw/rtl/mrrt_sphere_cmp.sv
// ------------------------------------------------------------------------------------------
// Refinement tagger ellipsoid compare
// Six stages: squares, radius products, partial products, merge, sum, compare.
// ------------------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrrt_sphere_cmp
    import mrrt_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_ok,
    input  wire logic [AXES-1:0][COORD_BITS-1:0]    i_off,
    input  wire logic [AXES-1:0][COORD_BITS-1:0]    i_rad,
    output logic                                    o_ok,
    output logic                                    o_le
);

    localparam int W   = COORD_BITS;
    localparam int W2  = 2 * W;
    localparam int W4  = 4 * W;
    localparam int W6  = 6 * W;
    localparam int W6S = W6 + 2;

    logic [SPH_LAT-1:0]     r_ok;

    logic [AXES-1:0][W2-1:0] r_a;
    logic [AXES-1:0][W2-1:0] r_b;

    logic [AXES-1:0][W2-1:0] r_a2;
    logic [W2-1:0]           r_bx2;
    logic [AXES-1:0][W4-1:0] r_bb;

    logic [AXES-1:0][W4-1:0] r_lo;
    logic [AXES-1:0][W4-1:0] r_hi;
    logic [W4-1:0]           r_qlo;
    logic [W4-1:0]           r_qhi;

    logic [AXES-1:0][W6-1:0] r_t;
    logic [W6-1:0]           r_q4;

    logic [W6S-1:0]          r_sum;
    logic [W6-1:0]           r_q5;

    logic                    r_le;

    always_ff @(posedge i_clk) begin
        r_ok <= {r_ok[SPH_LAT-2:0], i_ok};

        for (int a = 0; a < AXES; a++) begin
            r_a[a] <= W2'(i_off[a]) * W2'(i_off[a]);
            r_b[a] <= W2'(i_rad[a]) * W2'(i_rad[a]);
        end

        r_a2    <= r_a;
        r_bx2   <= r_b[0];
        r_bb[0] <= W4'(r_b[1]) * W4'(r_b[2]);
        r_bb[1] <= W4'(r_b[0]) * W4'(r_b[2]);
        r_bb[2] <= W4'(r_b[0]) * W4'(r_b[1]);

        for (int a = 0; a < AXES; a++) begin
            r_lo[a] <= W4'(r_a2[a]) * W4'(r_bb[a][W2-1:0]);
            r_hi[a] <= W4'(r_a2[a]) * W4'(r_bb[a][W4-1:W2]);
        end
        r_qlo <= W4'(r_bx2) * W4'(r_bb[0][W2-1:0]);
        r_qhi <= W4'(r_bx2) * W4'(r_bb[0][W4-1:W2]);

        for (int a = 0; a < AXES; a++) begin
            r_t[a] <= W6'(r_lo[a]) + (W6'(r_hi[a]) << W2);
        end
        r_q4 <= W6'(r_qlo) + (W6'(r_qhi) << W2);

        r_sum <= W6S'(r_t[0]) + W6S'(r_t[1]) + W6S'(r_t[2]);
        r_q5  <= r_q4;

        r_le <= (r_sum <= W6S'(r_q5));
    end

    assign o_ok = r_ok[SPH_LAT-1];
    assign o_le = r_le;

endmodule

`default_nettype wire

FILE: hw/rtl/multi_region_refinement_tagger_core.sv
// ------------------------------------------------------------------------------------------
// Multi-region refinement tagger core
// Flags grid points that fall inside any active box or ellipsoid refinement region.
//
//   channel   handshake            payload
//   point     start / busy         i_x_coord, i_y_coord, i_z_coord
//   result    o_valid (1 cycle)    o_refine
//   config    i_cfg_we             i_cfg_addr, i_cfg_wdata
//
// One point per clock; busy stays low, so a transfer happens on every cycle with start high.
// The path runs through the input register, two front-end stages, six multiply/compare
// stages per region and the output register; the multiplier chain sets that depth.
// Reset clears the registers and the valid pipeline; payload stages run free.
// The result cannot be stalled and appears for exactly one cycle.
// ------------------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_region_refinement_tagger_core
    import mrrt_pkg::*;
#(
    parameter int REGIONS    = 3,
    parameter int COORD_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COORD_BITS-1:0] i_x_coord,
    input  wire logic signed [COORD_BITS-1:0] i_y_coord,
    input  wire logic signed [COORD_BITS-1:0] i_z_coord,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_wdata,
    output logic                              o_valid,
    output logic                              o_refine
);

    t_region_ctrl [CFG_REGIONS-1:0]                     ctrl;
    logic [CFG_REGIONS-1:0][AXES-1:0][COORD_BITS-1:0]   center;
    logic [CFG_REGIONS-1:0][AXES-1:0][COORD_BITS-1:0]   radii;
    logic [AXES-1:0][COORD_BITS-1:0]                    spacing;

    logic [AXES-1:0][COORD_BITS-1:0]  r_point;
    logic [PIPE_LAT-1:0]              r_vld;
    logic                             r_refine;
    logic [REGIONS-1:0]               hit;
    logic                             accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    mrrt_cfg_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ctrl      (ctrl),
        .o_center    (center),
        .o_radii     (radii),
        .o_spacing   (spacing)
    );

    genvar g_r;
    generate
        for (g_r = 0; g_r < REGIONS; g_r++) begin : g_region
            logic                               front_ok;
            logic [AXES-1:0][COORD_BITS-1:0]    front_off;
            logic [AXES-1:0][COORD_BITS-1:0]    front_rad;
            logic                               sph_ok;
            logic                               sph_le;

            mrrt_region_front #(
                .COORD_BITS (COORD_BITS)
            ) u_front (
                .i_clk     (i_clk),
                .i_point   (r_point),
                .i_center  (center[g_r]),
                .i_radii   (radii[g_r]),
                .i_spacing (spacing),
                .o_ok      (front_ok),
                .o_off     (front_off),
                .o_rad     (front_rad)
            );

            mrrt_sphere_cmp #(
                .COORD_BITS (COORD_BITS)
            ) u_sphere (
                .i_clk (i_clk),
                .i_ok  (front_ok),
                .i_off (front_off),
                .i_rad (front_rad),
                .o_ok  (sph_ok),
                .o_le  (sph_le)
            );

            assign hit[g_r] = ctrl[g_r].active && sph_ok && (ctrl[g_r].cube || sph_le);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], accept};
        end
        r_point[0] <= i_x_coord;
        r_point[1] <= i_y_coord;
        r_point[2] <= i_z_coord;
        r_refine   <= |hit;
    end

    assign o_valid  = r_vld[PIPE_LAT-1];
    assign o_refine = r_refine;

endmodule

`default_nettype wire

FILE: hw/rtl/mrrt_checker.sv
// ------------------------------------------------------------------------------------------
// Refinement tagger checker
// Port-level assertions on latency and result gating, bound to the tagger core.
// ------------------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multi_region_refinement_tagger_core_assert.svh"

module mrrt_checker
    import mrrt_pkg::*;
#(
    parameter int REGIONS = 3
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  i_cfg_we,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input wire logic                  o_valid,
    input wire logic                  o_refine
);

    logic r_no_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_active <= 1'b1;
        end else if (i_cfg_we && (i_cfg_addr == REG_CONTROL)) begin
            r_no_active <= (i_cfg_wdata[REGIONS-1:0] == '0);
        end
    end

    `MRRT_ASSERT(a_transfer_gives_result, i_clk, i_rst_n, start && !busy |-> ##PIPE_LAT o_valid, "transfer without result")
    `MRRT_ASSERT(a_no_spurious_result, i_clk, i_rst_n, !(start && !busy) |-> ##PIPE_LAT !o_valid, "result without transfer")
    `MRRT_ASSERT_NEVER(a_refine_needs_region, i_clk, i_rst_n, o_valid && $past(r_no_active) && o_refine, "refine with no active region")

endmodule

bind multi_region_refinement_tagger_core mrrt_checker #(
    .REGIONS (REGIONS)
) u_mrrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_addr  (i_cfg_addr),
    .i_cfg_wdata (i_cfg_wdata),
    .o_valid     (o_valid),
    .o_refine    (o_refine)
);

`default_nettype wire

FILE: dv/tb_multi_region_refinement_tagger_core.sv
// ----------------------------------------------------------------------------
// Refinement tagger core testbench
// Drives grid points through the tagger under directed and random region
// setups, predicts the refine flag per point and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_region_refinement_tagger_core;
    import mrrt_pkg::*;

    localparam int CW             = 16;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_POINTS   = 105;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic signed [CW-1:0]  i_x_coord;
    logic signed [CW-1:0]  i_y_coord;
    logic signed [CW-1:0]  i_z_coord;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  o_valid;
    logic                  o_refine;

    logic [CFG_DATA_W-1:0] tagger_regs [8];
    logic                  refine_expected_q [$];
    int                    error_count;
    int                    idle_cycles;
    int                    gap_limit;

    multi_region_refinement_tagger_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .i_z_coord   (i_z_coord),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_refine    (o_refine)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [47:0] pack3(input int x, input int y, input int z);
        return {CW'(z), CW'(y), CW'(x)};
    endfunction

    function automatic logic point_in_region(input int r, input logic [47:0] pt, input logic cube);
        longint      pos;
        longint      ctr;
        longint      eff;
        longint      off_abs [3];
        longint      reach [3];
        logic [127:0] sq_off [3];
        logic [127:0] sq_rad [3];
        logic [127:0] lhs;
        logic [127:0] rhs;
        for (int axis = 0; axis < 3; axis++) begin
            pos = longint'($signed(pt[axis*CW +: CW]));
            ctr = longint'($signed(tagger_regs[REG_CENTER0 + r][axis*CW +: CW]));
            eff = longint'(tagger_regs[REG_RADII0 + r][axis*CW +: CW])
                - longint'(tagger_regs[REG_SPACING][axis*CW +: CW]);
            if (eff <= 0) return 1'b0;
            off_abs[axis] = (pos >= ctr) ? pos - ctr : ctr - pos;
            if (off_abs[axis] > eff) return 1'b0;
            reach[axis] = eff;
        end
        if (cube) return 1'b1;
        for (int axis = 0; axis < 3; axis++) begin
            sq_off[axis] = 128'(off_abs[axis] * off_abs[axis]);
            sq_rad[axis] = 128'(reach[axis] * reach[axis]);
        end
        lhs = sq_off[0] * sq_rad[1] * sq_rad[2]
            + sq_off[1] * sq_rad[0] * sq_rad[2]
            + sq_off[2] * sq_rad[0] * sq_rad[1];
        rhs = sq_rad[0] * sq_rad[1] * sq_rad[2];
        return lhs <= rhs;
    endfunction

    function automatic logic predict_refine(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                            input logic [CW-1:0] z);
        logic [CTRL_W-1:0] ctrl;
        logic              hit;
        ctrl = tagger_regs[REG_CONTROL][CTRL_W-1:0];
        hit  = 1'b0;
        for (int r = 0; r < CFG_REGIONS; r++) begin
            if (ctrl[r] && point_in_region(r, {z, y, x}, ctrl[CTRL_SHAPE_LSB + r]))
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic [CW-1:0] near_coord(input int r, input int axis, input bit at_edge);
        int ctr;
        int rad;
        int span;
        int off;
        ctr = int'($signed(tagger_regs[REG_CENTER0 + r][axis*CW +: CW]));
        rad = int'(tagger_regs[REG_RADII0 + r][axis*CW +: CW])
            - int'(tagger_regs[REG_SPACING][axis*CW +: CW]);
        if (rad < 1) rad = 1;
        if (at_edge) begin
            off = rad + int'($urandom_range(0, 1));
            if ($urandom_range(0, 1)) off = -off;
        end else begin
            span = rad + rad / 4 + 2;
            off  = int'($urandom_range(0, 2 * span)) - span;
        end
        return CW'(ctr + off);
    endfunction

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        idle_cycles = 0;
        @(posedge i_clk);
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (refine_expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual refine %0b",
                         $time, o_refine);
                error_count++;
            end else if (o_refine !== refine_expected_q[0]) begin
                $display("%0t: refine mismatch, expected %0b, actual %0b",
                         $time, refine_expected_q[0], o_refine);
                error_count++;
                void'(refine_expected_q.pop_front());
            end else begin
                void'(refine_expected_q.pop_front());
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = data;
        @(posedge i_clk);
        tagger_regs[idx] = (idx == REG_CONTROL) ? {42'b0, data[CTRL_W-1:0]} : data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic [CW-1:0] z);
        int gap;
        gap = $urandom_range(0, gap_limit);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start     = 1'b1;
        i_x_coord = x;
        i_y_coord = y;
        i_z_coord = z;
        do @(posedge i_clk); while (busy);
        refine_expected_q.push_back(predict_refine(x, y, z));
    endtask

    task automatic send_packed(input logic [47:0] pt);
        send_point(pt[CW-1:0], pt[2*CW-1:CW], pt[3*CW-1:2*CW]);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        start = 1'b0;
        while (refine_expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_packed(pack3(0, 0, 0));
        send_packed(pack3(32767, -32768, 32767));
        send_packed(pack3(-32768, 32767, -32768));
        wait_drain();
    endtask

    task automatic test_cube_bounds();
        write_reg(REG_SPACING, pack3(10, 10, 10));
        write_reg(REG_RADII0, pack3(100, 100, 100));
        write_reg(REG_CENTER0, pack3(0, 0, 0));
        write_reg(REG_CONTROL, 48'b001001);
        send_packed(pack3(90, 90, 90));
        send_packed(pack3(91, 0, 0));
        send_packed(pack3(-90, -90, -90));
        send_packed(pack3(0, -91, 0));
        send_packed(pack3(0, 0, 90));
        wait_drain();
    endtask

    task automatic test_sphere_surface();
        write_reg(REG_SPACING, pack3(0, 0, 0));
        write_reg(REG_CENTER1, pack3(100, -200, 300));
        write_reg(REG_RADII1, pack3(50, 60, 70));
        write_reg(REG_CONTROL, 48'b000010);
        send_packed(pack3(100, -200, 300));
        send_packed(pack3(150, -200, 300));
        send_packed(pack3(151, -200, 300));
        send_packed(pack3(140, -164, 300));
        send_packed(pack3(141, -164, 300));
        send_packed(pack3(150, -140, 370));
        wait_drain();
    endtask

    task automatic test_radius_not_above_spacing();
        write_reg(REG_CENTER2, pack3(0, 0, 0));
        write_reg(REG_RADII2, pack3(20, 20, 20));
        write_reg(REG_SPACING, pack3(5, 20, 5));
        write_reg(REG_CONTROL, 48'b100100);
        send_packed(pack3(0, 0, 0));
        wait_drain();
        write_reg(REG_SPACING, pack3(5, 25, 5));
        write_reg(REG_CONTROL, 48'b000100);
        send_packed(pack3(0, 0, 0));
        send_packed(pack3(1, 0, -1));
        wait_drain();
    endtask

    task automatic test_field_extremes();
        write_reg(REG_SPACING, 48'h0);
        write_reg(REG_CENTER0, pack3(-32768, -32768, -32768));
        write_reg(REG_RADII0, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_CENTER1, pack3(32767, 32767, 32767));
        write_reg(REG_RADII1, pack3(1, 1, 1));
        write_reg(REG_CONTROL, 48'hFFFF_FFFF_FFFF);
        send_packed(pack3(32767, 32767, 32767));
        send_packed(pack3(-32768, 0, 32767));
        wait_drain();
        // upper control bits must be dropped: region 0 sphere only
        write_reg(REG_CONTROL, 48'hFFFF_FFFF_FFC1);
        send_packed(pack3(32767, -32768, -32768));
        send_packed(pack3(32767, 32767, -32768));
        send_packed(pack3(-32768, -32768, -32768));
        send_packed(pack3(0, 0, 0));
        wait_drain();
    endtask

    task automatic test_pause_until_drained();
        gap_limit = 0;
        for (int i = 0; i < 10; i++)
            send_point(CW'($urandom), CW'($urandom), CW'($urandom));
        wait_drain();
        gap_limit = 11;
        for (int i = 0; i < 10; i++)
            send_point(near_coord(0, 0, 0), near_coord(0, 1, 0), near_coord(0, 2, 0));
        wait_drain();
    endtask

    task automatic test_random_phase(input int phase, input int n_points);
        int                    r;
        int                    mode;
        logic [CFG_DATA_W-1:0] word;
        logic [CW-1:0]         coord [3];
        wait_drain();
        for (r = 0; r < CFG_REGIONS; r++) begin
            write_reg(CFG_IDX_W'(REG_CENTER0 + r),
                      {CW'($urandom), CW'($urandom), CW'($urandom)});
            mode = $urandom_range(0, 9);
            if (phase == 0 || mode == 1)
                word = 48'hFFFF_FFFF_FFFF;
            else if (mode == 0)
                word = {CW'($urandom), CW'($urandom), CW'($urandom)};
            else
                word = pack3($urandom_range(1, 4000), $urandom_range(1, 4000),
                             $urandom_range(1, 4000));
            write_reg(CFG_IDX_W'(REG_RADII0 + r), word);
        end
        mode = $urandom_range(0, 9);
        if (phase == 0 || mode == 0)
            word = 48'h0;
        else if (phase == 1)
            word = 48'hFFFF_FFFF_FFFF;
        else if (mode == 1)
            word = {CW'($urandom), CW'($urandom), CW'($urandom)};
        else
            word = pack3($urandom_range(0, 50), $urandom_range(0, 50), $urandom_range(0, 50));
        write_reg(REG_SPACING, word);
        word = 48'({$urandom, $urandom});
        if (phase <= 1) word[2:0] = 3'b111;
        write_reg(REG_CONTROL, word);

        gap_limit = (phase % 3 == 2) ? 0 : 11;
        for (int i = 0; i < n_points; i++) begin
            r    = $urandom_range(0, CFG_REGIONS - 1);
            mode = $urandom_range(0, 9);
            for (int axis = 0; axis < 3; axis++) begin
                if (mode <= 5)
                    coord[axis] = near_coord(r, axis, 1'b0);
                else if (mode <= 7)
                    coord[axis] = near_coord(r, axis, $urandom_range(0, 1));
                else
                    coord[axis] = CW'($urandom);
            end
            send_point(coord[0], coord[1], coord[2]);
        end
        wait_drain();
    endtask

    initial begin
        error_count = 0;
        gap_limit   = 11;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_x_coord   = '0;
        i_y_coord   = '0;
        i_z_coord   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        for (int i = 0; i < 8; i++) tagger_regs[i] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_cube_bounds();
        test_sphere_surface();
        test_radius_not_above_spacing();
        test_field_extremes();
        test_pause_until_drained();
        for (int p = 0; p < RANDOM_PHASES; p++)
            test_random_phase(p, PHASE_POINTS);

        wait_drain();
        repeat (PIPE_LAT + 5) @(posedge i_clk);
        if (refine_expected_q.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, refine_expected_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/mrrt_pkg.sv
hw/rtl/mrrt_cfg_regs.sv
hw/rtl/mrrt_region_front.sv
hw/rtl/mrrt_sphere_cmp.sv
hw/rtl/multi_region_refinement_tagger_core.sv
hw/rtl/mrrt_checker.sv
dv/tb_multi_region_refinement_tagger_core.sv
